@@ rtl/vps_pkg.sv @@
// Shared types, constants and step ROM of the vibration pattern sequencer.
package vps_pkg;

  // Pattern steps scanned per tick before the pattern is declared exhausted.
  localparam int SCAN_ROWS = 4;
  localparam int IDX_W     = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;

  localparam int ROM_ROWS  = 4;
  localparam int ROM_IDX_W = 2;
  localparam int NUM_PAT   = 4;

  localparam int FUNC_W = 2;
  localparam int TIME_W = 32;
  localparam int PAT_W  = 3;
  localparam int MS_W   = 16;

  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLAY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

  localparam logic [PAT_W-1:0] PAT_NONE  = 3'd0;
  localparam logic [PAT_W-1:0] PAT_FIRST = 3'd1;
  localparam logic [PAT_W-1:0] PAT_LAST  = 3'd4;

  typedef struct packed {
    logic [MS_W-1:0] on_ms;
    logic [MS_W-1:0] off_ms;
  } step_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // input word taken this cycle
    logic step;    // evaluate one ROM step of the running pattern
  } vps_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic walk_req;   // the word at the input is a tick that needs a step walk
    logic walk_done;  // the step evaluated this cycle ends the walk
  } vps_sts_t;

  localparam step_t STEP_ROM [NUM_PAT][ROM_ROWS] = '{
    '{'{16'd200, 16'd100}, '{16'd200, 16'd100}, '{16'd400, 16'd0},   '{16'd0, 16'd0}},
    '{'{16'd100, 16'd100}, '{16'd100, 16'd0},   '{16'd0,   16'd0},   '{16'd0, 16'd0}},
    '{'{16'd100, 16'd0},   '{16'd0,   16'd0},   '{16'd0,   16'd0},   '{16'd0, 16'd0}},
    '{'{16'd50,  16'd50},  '{16'd50,  16'd50},  '{16'd50,  16'd0},   '{16'd0, 16'd0}}
  };

  // Rows past the stored ones read as terminators. pat must be 1..4.
  function automatic step_t step_lookup(input logic [PAT_W-1:0] pat,
                                        input logic [IDX_W-1:0] idx);
    logic [PAT_W-1:0]           pat_m1;
    logic [IDX_W+ROM_IDX_W-1:0] idx_ext;
    step_t                      row;
    pat_m1  = pat - PAT_FIRST;
    idx_ext = {{ROM_IDX_W{1'b0}}, idx};
    if (idx_ext < (IDX_W + ROM_IDX_W)'(ROM_ROWS)) begin
      row = STEP_ROM[pat_m1[ROM_IDX_W-1:0]][idx_ext[ROM_IDX_W-1:0]];
    end else begin
      row = '0;
    end
    return row;
  endfunction

endpackage

@@ rtl/vps_if.sv @@
// Handshake interfaces for the command and result channels.
interface vps_in_if;
  logic                           valid;
  logic                           ready;
  logic [vps_pkg::FUNC_W-1:0]     func;
  logic [vps_pkg::TIME_W-1:0]     now_time;
  logic [vps_pkg::PAT_W-1:0]      pattern_id;

  modport source (output valid, func, now_time, pattern_id, input ready);
  modport sink   (input valid, func, now_time, pattern_id, output ready);
endinterface

interface vps_out_if;
  logic                           valid;
  logic                           ready;
  logic                           motor_on;
  logic                           busy_res;
  logic [vps_pkg::PAT_W-1:0]      waiting_pattern;

  modport source (output valid, motor_on, busy_res, waiting_pattern, input ready);
  modport sink   (input valid, motor_on, busy_res, waiting_pattern, output ready);
endinterface

@@ rtl/vps_ctrl.sv @@
// Sequencer control FSM: handshakes and step-walk sequencing.
module vps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vps_pkg::vps_sts_t sts,
  output vps_pkg::vps_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // result register is free or drains this cycle
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.accept    = 1'b0;
    cmd.step      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
        end
        if (accept) begin
          cmd.accept = 1'b1;
          if (sts.walk_req) begin
            state_nxt = ST_WALK;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/vps_datapath.sv @@
// Sequencer state, command decode and one-step-per-cycle pattern walk.
module vps_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [vps_pkg::FUNC_W-1:0]  func,
  input  logic [vps_pkg::TIME_W-1:0]  now_time,
  input  logic [vps_pkg::PAT_W-1:0]   pattern_id,
  input  vps_pkg::vps_cmd_t           cmd,
  output vps_pkg::vps_sts_t           sts,
  output logic                        motor_on,
  output logic                        busy_res,
  output logic [vps_pkg::PAT_W-1:0]   waiting_pattern
);

  logic                         active_r,  active_nxt;
  logic [vps_pkg::PAT_W-1:0]    running_r, running_nxt;
  logic [vps_pkg::TIME_W-1:0]   start_r,   start_nxt;
  logic [vps_pkg::PAT_W-1:0]    queued_r,  queued_nxt;
  logic                         motor_r,   motor_nxt;
  logic [vps_pkg::TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [vps_pkg::TIME_W-1:0]   now_r,     now_nxt;
  logic [vps_pkg::TIME_W-1:0]   accum_r,   accum_nxt;
  logic [vps_pkg::IDX_W-1:0]    idx_r,     idx_nxt;

  vps_pkg::step_t               row;
  logic [vps_pkg::MS_W:0]       len;
  logic [vps_pkg::TIME_W-1:0]   end_sum;
  logic [vps_pkg::TIME_W-1:0]   on_sum;
  logic                         is_term;
  logic                         is_last;
  logic                         in_step;
  logic                         pat_ok;

  assign pat_ok  = running_r inside {[vps_pkg::PAT_FIRST:vps_pkg::PAT_LAST]};
  assign row     = vps_pkg::step_lookup(running_r, idx_r);
  assign len     = {1'b0, row.on_ms} + {1'b0, row.off_ms};
  assign end_sum = accum_r + {{(vps_pkg::TIME_W-vps_pkg::MS_W-1){1'b0}}, len};
  assign on_sum  = accum_r + {{(vps_pkg::TIME_W-vps_pkg::MS_W){1'b0}}, row.on_ms};
  assign is_term = (row.on_ms == '0) && (row.off_ms == '0);
  assign is_last = (idx_r == vps_pkg::IDX_W'(vps_pkg::SCAN_ROWS - 1));
  assign in_step = (elapsed_r < end_sum);

  assign sts.walk_req  = (func == vps_pkg::FUNC_TICK) && active_r && pat_ok;
  assign sts.walk_done = is_term || in_step || is_last;

  assign motor_on        = motor_r;
  assign busy_res        = active_r;
  assign waiting_pattern = queued_r;

  always_comb begin
    active_nxt  = active_r;
    running_nxt = running_r;
    start_nxt   = start_r;
    queued_nxt  = queued_r;
    motor_nxt   = motor_r;
    elapsed_nxt = elapsed_r;
    now_nxt     = now_r;
    accum_nxt   = accum_r;
    idx_nxt     = idx_r;

    if (cmd.accept) begin
      case (func)
        vps_pkg::FUNC_TICK: begin
          if (active_r) begin
            if (pat_ok) begin
              elapsed_nxt = now_time - start_r;
              now_nxt     = now_time;
              accum_nxt   = '0;
              idx_nxt     = '0;
            end else begin
              active_nxt = 1'b0;  // pattern without ROM just ends
            end
          end
        end
        vps_pkg::FUNC_PLAY: begin
          if (active_r) begin
            queued_nxt = pattern_id;
          end else begin
            motor_nxt   = 1'b0;
            running_nxt = pattern_id;
            start_nxt   = now_time;
            active_nxt  = 1'b1;
          end
        end
        vps_pkg::FUNC_STOP: begin
          active_nxt = 1'b0;
          motor_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      if (is_term) begin
        motor_nxt  = 1'b0;
        active_nxt = 1'b0;
        if (queued_r != vps_pkg::PAT_NONE) begin
          queued_nxt  = vps_pkg::PAT_NONE;
          running_nxt = queued_r;
          start_nxt   = now_r;
          active_nxt  = 1'b1;
        end
      end else if (in_step) begin
        motor_nxt = (elapsed_r < on_sum);
      end else if (is_last) begin
        // ran out of rows without a terminator: stop, queue untouched
        motor_nxt  = 1'b0;
        active_nxt = 1'b0;
      end else begin
        accum_nxt = end_sum;
        idx_nxt   = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      running_r <= vps_pkg::PAT_NONE;
      start_r   <= '0;
      queued_r  <= vps_pkg::PAT_NONE;
      motor_r   <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      running_r <= running_nxt;
      start_r   <= start_nxt;
      queued_r  <= queued_nxt;
      motor_r   <= motor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
    now_r     <= now_nxt;
    accum_r   <= accum_nxt;
    idx_r     <= idx_nxt;
  end

endmodule

@@ rtl/vibration_pattern_sequencer.sv @@
// Top level of the vibration pattern sequencer.
//
// Usage:
//   in_ch  carries one command word: func (tick / play / stop), now_time in
//          ms and pattern_id. One result word per command on out_ch:
//          motor_on, busy_res and waiting_pattern as they stand after it.
//   Play, stop, unused codes and ticks that need no step walk give their
//   result the cycle after acceptance. A tick on a running pattern walks
//   the step ROM one row per cycle, up to SCAN_ROWS (4) rows.
//   Throughput: one word is in flight at a time; a new word is taken in the
//   cycle its predecessor's result is taken, so short commands run at one
//   word per cycle while out_ch.ready is high; a walking tick holds the
//   next word off while the single row read / add / compare unit walks.
//   Reset (rst_n low, synchronous): idle, motor off, no pattern, empty queue,
//   no result pending.
//   Stall: while out_ch.ready is low the result word holds and in_ch.ready
//   stays low; no state changes until the result is taken.
module vibration_pattern_sequencer (
  input logic        clk,
  input logic        rst_n,
  vps_in_if.sink     in_ch,
  vps_out_if.source  out_ch
);

  vps_pkg::vps_cmd_t cmd;
  vps_pkg::vps_sts_t sts;

  vps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vps_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .func            (in_ch.func),
    .now_time        (in_ch.now_time),
    .pattern_id      (in_ch.pattern_id),
    .cmd             (cmd),
    .sts             (sts),
    .motor_on        (out_ch.motor_on),
    .busy_res        (out_ch.busy_res),
    .waiting_pattern (out_ch.waiting_pattern)
  );

  // While walking, nothing is taken and no result is shown.
  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!in_ch.ready && !out_ch.valid))
    else $error("input taken or result shown during step walk");

  // A word that needs no walk has its result the next cycle.
  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !sts.walk_req) |=> (out_ch.valid && !cmd.step))
    else $error("short command produced no result");

  // The end of a walk hands over exactly one result.
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.walk_done) |=> (out_ch.valid && !cmd.step))
    else $error("step walk ended without a result");

  // A walk never starts while a result waits.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && sts.walk_req) |=> (cmd.step && !out_ch.valid))
    else $error("tick did not start a step walk");

endmodule
